[hdl/tilt_compensation_with_stability_flag_macros.svh]
// Assertion macros used by the tilt compensation top level.
`ifndef TILT_COMPENSATION_WITH_STABILITY_FLAG_MACROS_SVH
`define TILT_COMPENSATION_WITH_STABILITY_FLAG_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCSF_ASSERT_HOLDS(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tilt compensation check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCSF_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tilt compensation sequencing check failed");

`endif

[hdl/tcsf_pkg.sv]
// Types, constants and arithmetic helpers for the tilt compensation block.
`timescale 1ns / 1ps

package tcsf_pkg;

   localparam logic [8:0]  CoefOne        = 9'd256;
   localparam logic [13:0] CalmCompLimit  = 14'd128;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_CMUL,
      ST_CLAMP,
      ST_MERGE
   } tcsf_state_type;

   typedef enum logic [2:0] {
      REG_ENABLED,
      REG_FILTER_ALPHA,
      REG_COMP_GAIN,
      REG_DECAY_FACTOR,
      REG_DEADBAND,
      REG_MAX_COMP,
      REG_STABLE_THRESHOLD,
      REG_STABLE_CYCLES
   } tcsf_reg_type;

   typedef struct packed {
      logic mul_en;
      logic sum_en;
      logic cmul_en;
      logic clamp_en;
      logic merge_en;
      logic upd;
      logic clear;
   } tcsf_ctrl_type;

   typedef struct packed {
      logic [8:0]  alpha;
      logic [8:0]  gain;
      logic [8:0]  decay;
      logic [11:0] deadband;
      logic [11:0] max_comp;
   } tcsf_axis_cfg_type;

   typedef struct packed {
      logic [15:0] adjusted_roll;
      logic [15:0] adjusted_pitch;
      logic        stable;
      logic [12:0] roll_comp;
      logic [12:0] pitch_comp;
   } tcsf_result_type;

   // Coefficients above one are used as one.
   function automatic logic [8:0] sat_coef(input logic [8:0] c);
      return (c > CoefOne) ? CoefOne : c;
   endfunction

   // Signed divide by 256 rounding toward zero.
   function automatic logic signed [18:0] tdiv(input logic signed [26:0] x);
      logic signed [26:0] b;
      b = x + (x[26] ? 27'sd255 : 27'sd0);
      return b[26:8];
   endfunction

   function automatic logic [12:0] abs13(input logic signed [12:0] x);
      return x[12] ? 13'(-x) : 13'(x);
   endfunction

   function automatic logic [16:0] abs16(input logic signed [15:0] x);
      logic signed [16:0] w;
      w = 17'(x);
      return w[16] ? 17'(-w) : 17'(w);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [16:0] x);
      if (x > 17'sd32767) begin
         return 16'sh7FFF;
      end else if (x < -17'sd32768) begin
         return 16'sh8000;
      end
      return x[15:0];
   endfunction

endpackage

[hdl/tcsf_lane.sv]
// One axis lane: low-pass filter, gain or decay product, and clamp.
`timescale 1ns / 1ps

module tcsf_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  tcsf_pkg::tcsf_ctrl_type        ctrl,
   input  tcsf_pkg::tcsf_axis_cfg_type    cfg,
   input  logic signed [15:0]             measured,
   output logic signed [15:0]             smoothed,
   output logic signed [12:0]             offset
);
   import tcsf_pkg::*;

   logic [8:0]         alpha;
   logic [8:0]         inv_alpha;
   logic signed [26:0] prod_old_ff, prod_old_in;
   logic signed [26:0] prod_new_ff, prod_new_in;
   logic signed [26:0] wsum;
   logic signed [18:0] filt_q;
   logic signed [15:0] filt;
   logic [16:0]        filt_abs;
   logic signed [15:0] smooth_ff, smooth_in;
   logic               comp_sel_ff, comp_sel_in;
   logic signed [15:0] operand;
   logic [8:0]         coef_sel;
   logic signed [26:0] mprod_ff, mprod_in;
   logic signed [18:0] quot;
   logic signed [18:0] raw;
   logic signed [18:0] limit;
   logic signed [18:0] clamped;
   logic signed [12:0] offset_ff, offset_in;

   assign alpha       = sat_coef(cfg.alpha);
   assign inv_alpha   = CoefOne - alpha;
   assign prod_old_in = smooth_ff * $signed({1'b0, inv_alpha});
   assign prod_new_in = measured * $signed({1'b0, alpha});

   assign wsum        = prod_old_ff + prod_new_ff;
   assign filt_q      = tdiv(wsum);
   assign filt        = filt_q[15:0];
   assign filt_abs    = abs16(filt);
   assign comp_sel_in = filt_abs > {5'd0, cfg.deadband};

   assign operand  = comp_sel_ff ? smooth_ff : 16'(offset_ff);
   assign coef_sel = comp_sel_ff ? sat_coef(cfg.gain) : sat_coef(cfg.decay);
   assign mprod_in = operand * $signed({1'b0, coef_sel});

   assign quot  = tdiv(mprod_ff);
   assign raw   = comp_sel_ff ? -quot : quot;
   assign limit = $signed({7'd0, cfg.max_comp});

   always_comb begin
      if (raw > limit) begin
         clamped = limit;
      end else if (raw < -limit) begin
         clamped = -limit;
      end else begin
         clamped = raw;
      end
   end

   always_comb begin
      smooth_in = smooth_ff;
      offset_in = offset_ff;
      if (ctrl.clear) begin
         smooth_in = '0;
         offset_in = '0;
      end else begin
         if (ctrl.sum_en && ctrl.upd) begin
            smooth_in = filt;
         end
         if (ctrl.clamp_en && ctrl.upd) begin
            offset_in = clamped[12:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
         offset_ff <= '0;
      end else begin
         smooth_ff <= smooth_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_old_ff <= prod_old_in;
         prod_new_ff <= prod_new_in;
      end
      if (ctrl.sum_en) begin
         comp_sel_ff <= comp_sel_in;
      end
      if (ctrl.cmul_en) begin
         mprod_ff <= mprod_in;
      end
   end

   assign smoothed = smooth_ff;
   assign offset   = offset_ff;

endmodule

[hdl/tcsf_merge.sv]
// Merge stage: calm run and stable flag, setpoint sums and result assembly.
`timescale 1ns / 1ps

module tcsf_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  tcsf_pkg::tcsf_ctrl_type    ctrl,
   input  logic [11:0]                stable_threshold,
   input  logic [7:0]                 stable_cycles,
   input  logic signed [15:0]         smoothed_roll,
   input  logic signed [15:0]         smoothed_pitch,
   input  logic signed [12:0]         offset_roll,
   input  logic signed [12:0]         offset_pitch,
   input  logic signed [15:0]         setpoint_roll,
   input  logic signed [15:0]         setpoint_pitch,
   output tcsf_pkg::tcsf_result_type  result
);
   import tcsf_pkg::*;

   logic [17:0]        err_sum;
   logic [13:0]        comp_sum;
   logic               calm;
   logic [7:0]         run_ff, run_in, run_next;
   logic               flag_ff, flag_in, flag_next;
   logic signed [15:0] adj_roll, adj_pitch;

   assign err_sum  = {1'b0, abs16(smoothed_roll)} + {1'b0, abs16(smoothed_pitch)};
   assign comp_sum = {1'b0, abs13(offset_roll)} + {1'b0, abs13(offset_pitch)};
   assign calm     = (err_sum < {6'd0, stable_threshold}) && (comp_sum < CalmCompLimit);

   assign run_next  = !calm ? 8'd0 : ((run_ff == 8'hFF) ? run_ff : run_ff + 8'd1);
   assign flag_next = calm && (flag_ff || (run_next >= stable_cycles));

   always_comb begin
      run_in  = run_ff;
      flag_in = flag_ff;
      if (ctrl.clear) begin
         run_in  = '0;
         flag_in = 1'b0;
      end else if (ctrl.merge_en && ctrl.upd) begin
         run_in  = run_next;
         flag_in = flag_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= '0;
         flag_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         flag_ff <= flag_in;
      end
   end

   assign adj_roll  = sat16(17'(setpoint_roll) + 17'(offset_roll));
   assign adj_pitch = sat16(17'(setpoint_pitch) + 17'(offset_pitch));

   always_comb begin
      if (ctrl.upd) begin
         result.adjusted_roll  = adj_roll;
         result.adjusted_pitch = adj_pitch;
         result.stable         = flag_next;
         result.roll_comp      = offset_roll;
         result.pitch_comp     = offset_pitch;
      end else begin
         result.adjusted_roll  = setpoint_roll;
         result.adjusted_pitch = setpoint_pitch;
         result.stable         = 1'b0;
         result.roll_comp      = '0;
         result.pitch_comp     = '0;
      end
   end

endmodule

[hdl/tilt_compensation_with_stability_flag.sv]
// Top level of the tilt compensation block with stability flag.
`timescale 1ns / 1ps
`include "tilt_compensation_with_stability_flag_macros.svh"

// Each word goes from acceptance to a loaded result through these states:
// ST_IDLE takes the word, ST_MUL and ST_SUM form the filter products and the
// weighted sum in each axis lane, ST_CMUL and ST_CLAMP the gain or decay
// product and the clamp, and ST_MERGE updates the stable flag and loads the
// output register. The roll and pitch lanes run side by side; a new word is
// taken only in ST_IDLE, after the last one is loaded. The output register
// holds a finished result while the next word is already being worked on;
// only the merge step waits if the previous result has not been taken yet.

module tilt_compensation_with_stability_flag (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // measured_roll, measured_pitch, setpoint_roll, setpoint_pitch
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // adjusted_roll, adjusted_pitch, attitude_stable, roll_compensation,
   // pitch_compensation, zero fill
   output logic [63:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [11:0] csr_wdata
);
   import tcsf_pkg::*;

   logic               enabled_ff, enabled_in;
   logic [8:0]         alpha_ff, alpha_in;
   logic [8:0]         gain_ff, gain_in;
   logic [8:0]         decay_ff, decay_in;
   logic [11:0]        deadband_ff, deadband_in;
   logic [11:0]        max_comp_ff, max_comp_in;
   logic [11:0]        threshold_ff, threshold_in;
   logic [7:0]         cycles_ff, cycles_in;
   tcsf_reg_type       reg_sel;

   tcsf_state_type     state_ff, state_in;
   logic [63:0]        in_word_ff;
   logic               in_accept;
   logic               out_load;
   logic               rsp_valid_ff, rsp_valid_in;
   tcsf_result_type    rsp_word_ff;
   tcsf_result_type    result;
   tcsf_ctrl_type      ctrl;
   tcsf_axis_cfg_type  axis_cfg;

   logic signed [15:0] smoothed_roll, smoothed_pitch;
   logic signed [12:0] offset_roll, offset_pitch;
   logic [13:0]        out_comp_sum;
   logic               merge_stalled;
   logic               stable_out;

   // Configuration registers.
   assign reg_sel = tcsf_reg_type'(csr_addr);

   always_comb begin
      enabled_in   = enabled_ff;
      alpha_in     = alpha_ff;
      gain_in      = gain_ff;
      decay_in     = decay_ff;
      deadband_in  = deadband_ff;
      max_comp_in  = max_comp_ff;
      threshold_in = threshold_ff;
      cycles_in    = cycles_ff;
      if (csr_we) begin
         case (reg_sel)
            REG_ENABLED:          enabled_in   = csr_wdata[0];
            REG_FILTER_ALPHA:     alpha_in     = csr_wdata[8:0];
            REG_COMP_GAIN:        gain_in      = csr_wdata[8:0];
            REG_DECAY_FACTOR:     decay_in     = csr_wdata[8:0];
            REG_DEADBAND:         deadband_in  = csr_wdata;
            REG_MAX_COMP:         max_comp_in  = csr_wdata;
            REG_STABLE_THRESHOLD: threshold_in = csr_wdata;
            REG_STABLE_CYCLES:    cycles_in    = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         alpha_ff     <= 9'd77;
         gain_ff      <= 9'd218;
         decay_ff     <= 9'd230;
         deadband_ff  <= 12'd38;
         max_comp_ff  <= 12'd1024;
         threshold_ff <= 12'd192;
         cycles_ff    <= 8'd15;
      end else begin
         enabled_ff   <= enabled_in;
         alpha_ff     <= alpha_in;
         gain_ff      <= gain_in;
         decay_ff     <= decay_in;
         deadband_ff  <= deadband_in;
         max_comp_ff  <= max_comp_in;
         threshold_ff <= threshold_in;
         cycles_ff    <= cycles_in;
      end
   end

   assign axis_cfg.alpha    = alpha_ff;
   assign axis_cfg.gain     = gain_ff;
   assign axis_cfg.decay    = decay_ff;
   assign axis_cfg.deadband = deadband_ff;
   assign axis_cfg.max_comp = max_comp_ff;

   // Sequencer.
   assign in_accept = req_tvalid && req_tready;
   assign out_load  = (state_ff == ST_MERGE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_CMUL;
         ST_CMUL:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_MERGE;
         ST_MERGE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      ctrl.mul_en   = 1'b0;
      ctrl.sum_en   = 1'b0;
      ctrl.cmul_en  = 1'b0;
      ctrl.clamp_en = 1'b0;
      ctrl.merge_en = 1'b0;
      ctrl.upd      = enabled_ff;
      ctrl.clear    = csr_we && (reg_sel == REG_ENABLED) && csr_wdata[0];
      case (state_ff)
         ST_IDLE:  req_tready    = 1'b1;
         ST_MUL:   ctrl.mul_en   = 1'b1;
         ST_SUM:   ctrl.sum_en   = 1'b1;
         ST_CMUL:  ctrl.cmul_en  = 1'b1;
         ST_CLAMP: ctrl.clamp_en = 1'b1;
         ST_MERGE: ctrl.merge_en = out_load;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         in_word_ff <= req_tdata;
      end
   end

   // Axis lanes and merge stage.
   tcsf_lane u_lane_roll (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cfg      (axis_cfg),
      .measured ($signed(in_word_ff[15:0])),
      .smoothed (smoothed_roll),
      .offset   (offset_roll)
   );

   tcsf_lane u_lane_pitch (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cfg      (axis_cfg),
      .measured ($signed(in_word_ff[31:16])),
      .smoothed (smoothed_pitch),
      .offset   (offset_pitch)
   );

   tcsf_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stable_threshold (threshold_ff),
      .stable_cycles    (cycles_ff),
      .smoothed_roll    (smoothed_roll),
      .smoothed_pitch   (smoothed_pitch),
      .offset_roll      (offset_roll),
      .offset_pitch     (offset_pitch),
      .setpoint_roll    ($signed(in_word_ff[47:32])),
      .setpoint_pitch   ($signed(in_word_ff[63:48])),
      .result           (result)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_word_ff.pitch_comp, rsp_word_ff.roll_comp,
                        rsp_word_ff.stable, rsp_word_ff.adjusted_pitch,
                        rsp_word_ff.adjusted_roll};

   assign out_comp_sum = {1'b0, abs13(rsp_word_ff.roll_comp)}
                       + {1'b0, abs13(rsp_word_ff.pitch_comp)};

   assign merge_stalled = (state_ff == ST_MERGE) && rsp_tvalid && !rsp_tready;
   assign stable_out    = rsp_tvalid && rsp_word_ff.stable;

   `TCSF_ASSERT_NEXT(a_accept_starts_lanes, in_accept, state_ff == ST_MUL)
   `TCSF_ASSERT_NEXT(a_merge_waits_for_sink, merge_stalled, state_ff == ST_MERGE)
   `TCSF_ASSERT_HOLDS(a_stable_means_small_comp, stable_out, out_comp_sum < CalmCompLimit)

endmodule

[bench/tilt_compensation_checker.sv]
// Checker that predicts each tilt compensation result and compares it with the block's output.
`timescale 1ns / 1ps

module tilt_compensation_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [11:0] csr_wdata,
   output int          mismatches,
   output int          words_in_flight
);

   import tcsf_pkg::*;

   localparam int Q_UNIT     = 256;
   localparam int CALM_COMP  = 128;

   logic               enabled_r;
   logic [8:0]         alpha_r;
   logic [8:0]         gain_r;
   logic [8:0]         decay_r;
   logic [11:0]        deadband_r;
   logic [11:0]        max_comp_r;
   logic [11:0]        threshold_r;
   logic [7:0]         calm_needed_r;

   logic signed [15:0] smooth_roll;
   logic signed [15:0] smooth_pitch;
   logic signed [12:0] comp_roll;
   logic signed [12:0] comp_pitch;
   logic [7:0]         calm_count;
   logic               steady;

   tcsf_result_type    results_due[$];

   initial mismatches = 0;

   function automatic int coef_value(input logic [8:0] c);
      return (c > 9'd256) ? Q_UNIT : int'(c);
   endfunction

   function automatic int magnitude(input int x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic int limit(input int x, input int lo, input int hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   task automatic clear_attitude();
      smooth_roll  = '0;
      smooth_pitch = '0;
      comp_roll    = '0;
      comp_pitch   = '0;
      calm_count   = '0;
      steady       = 1'b0;
   endtask

   task automatic set_defaults();
      enabled_r     = 1'b0;
      alpha_r       = 9'd77;
      gain_r        = 9'd218;
      decay_r       = 9'd230;
      deadband_r    = 12'd38;
      max_comp_r    = 12'd1024;
      threshold_r   = 12'd192;
      calm_needed_r = 8'd15;
      clear_attitude();
   endtask

   task automatic filter_axis(input int meas, inout logic signed [15:0] smooth,
                              inout logic signed [12:0] comp);
      int a;
      int s;
      int c;
      int m;
      a = coef_value(alpha_r);
      s = (int'(smooth) * (Q_UNIT - a) + meas * a) / Q_UNIT;
      smooth = 16'(s);
      if (magnitude(s) > int'(deadband_r)) begin
         c = -(s * coef_value(gain_r)) / Q_UNIT;
      end else begin
         c = (int'(comp) * coef_value(decay_r)) / Q_UNIT;
      end
      m = int'(max_comp_r);
      comp = 13'(limit(c, -m, m));
   endtask

   task automatic compensate_word(input logic [63:0] w, output tcsf_result_type r);
      int adj_roll;
      int adj_pitch;
      r = '0;
      adj_roll  = int'($signed(w[47:32]));
      adj_pitch = int'($signed(w[63:48]));
      if (enabled_r) begin
         filter_axis(int'($signed(w[15:0])), smooth_roll, comp_roll);
         filter_axis(int'($signed(w[31:16])), smooth_pitch, comp_pitch);
         adj_roll  = limit(adj_roll + int'(comp_roll), -32768, 32767);
         adj_pitch = limit(adj_pitch + int'(comp_pitch), -32768, 32767);
         if (magnitude(smooth_roll) + magnitude(smooth_pitch) < int'(threshold_r) &&
             magnitude(comp_roll) + magnitude(comp_pitch) < CALM_COMP) begin
            if (calm_count != 8'd255) begin
               calm_count = calm_count + 8'd1;
            end
            if (calm_count >= calm_needed_r) begin
               steady = 1'b1;
            end
         end else begin
            calm_count = '0;
            steady     = 1'b0;
         end
         r.stable     = steady;
         r.roll_comp  = comp_roll;
         r.pitch_comp = comp_pitch;
      end
      r.adjusted_roll  = 16'(adj_roll);
      r.adjusted_pitch = 16'(adj_pitch);
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
      end
   endtask

   always @(posedge clock) begin : watch
      tcsf_result_type want;
      if (reset) begin
         set_defaults();
         results_due.delete();
         words_in_flight <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_ENABLED: begin
                  enabled_r = csr_wdata[0];
                  if (csr_wdata[0]) begin
                     clear_attitude();
                  end
               end
               REG_FILTER_ALPHA:     alpha_r       = csr_wdata[8:0];
               REG_COMP_GAIN:        gain_r        = csr_wdata[8:0];
               REG_DECAY_FACTOR:     decay_r       = csr_wdata[8:0];
               REG_DEADBAND:         deadband_r    = csr_wdata;
               REG_MAX_COMP:         max_comp_r    = csr_wdata;
               REG_STABLE_THRESHOLD: threshold_r   = csr_wdata;
               REG_STABLE_CYCLES:    calm_needed_r = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               report_mismatch($sformatf("result %h with no word outstanding", rsp_tdata));
            end else begin
               want = results_due.pop_front();
               check_field("adjusted_roll", rsp_tdata[15:0], want.adjusted_roll);
               check_field("adjusted_pitch", rsp_tdata[31:16], want.adjusted_pitch);
               check_field("attitude_stable", 16'(rsp_tdata[32]), 16'(want.stable));
               check_field("roll_compensation", 16'(rsp_tdata[45:33]), 16'(want.roll_comp));
               check_field("pitch_compensation", 16'(rsp_tdata[58:46]),
                           16'(want.pitch_comp));
            end
         end
         if (req_tvalid && req_tready) begin
            compensate_word(req_tdata, want);
            results_due.push_back(want);
         end
         words_in_flight <= results_due.size();
      end
   end

endmodule

[bench/testbench.sv]
// Top of the tilt compensation testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;

   import tcsf_pkg::*;

   typedef enum {CALM_ANGLES, MODERATE_ANGLES, ANY_ANGLES} angle_style_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [11:0] csr_wdata  = '0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [63:0] rsp_tdata;
   int          mismatches;
   int          words_in_flight;
   int          idle_pct   = 0;
   int          stall_pct  = 0;

   tilt_compensation_with_stability_flag DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   tilt_compensation_checker attitude_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .words_in_flight (words_in_flight)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [63:0] pack_word(input int mr, input int mp, input int sr,
                                             input int sp);
      return {16'(sp), 16'(sr), 16'(mp), 16'(mr)};
   endfunction

   function automatic logic [63:0] random_word(input angle_style_type style);
      int mr;
      int mp;
      mr = $urandom;
      mp = $urandom;
      case (style)
         CALM_ANGLES: begin
            mr = int'($urandom_range(0, 100)) - 50;
            mp = int'($urandom_range(0, 100)) - 50;
         end
         MODERATE_ANGLES: begin
            mr = int'($urandom_range(0, 6000)) - 3000;
            mp = int'($urandom_range(0, 6000)) - 3000;
         end
         default: ;
      endcase
      return pack_word(mr, mp, $urandom, $urandom);
   endfunction

   task automatic set_idling(input int mode);
      case (mode)
         1:       begin idle_pct = 53; stall_pct = 0;  end
         2:       begin idle_pct = 0;  stall_pct = 53; end
         3:       begin idle_pct = 23; stall_pct = 23; end
         default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   task automatic send_word(input logic [63:0] w);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
   endtask

   task automatic write_reg(input tcsf_reg_type idx, input logic [11:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_one(input tcsf_reg_type idx, input logic [11:0] value);
      drain();
      write_reg(idx, value);
      csr_we <= 1'b0;
   endtask

   task automatic program_all(input logic en, input logic [11:0] alpha,
                              input logic [11:0] gain, input logic [11:0] decay,
                              input logic [11:0] dband, input logic [11:0] maxc,
                              input logic [11:0] thr, input logic [11:0] cycles);
      drain();
      write_reg(REG_FILTER_ALPHA, alpha);
      write_reg(REG_COMP_GAIN, gain);
      write_reg(REG_DECAY_FACTOR, decay);
      write_reg(REG_DEADBAND, dband);
      write_reg(REG_MAX_COMP, maxc);
      write_reg(REG_STABLE_THRESHOLD, thr);
      write_reg(REG_STABLE_CYCLES, cycles);
      write_reg(REG_ENABLED, {11'($urandom), en});
      csr_we <= 1'b0;
   endtask

   function automatic logic [11:0] pick_coef();
      case ($urandom_range(0, 5))
         0:       return 12'd256;
         1:       return 12'($urandom_range(257, 4095));
         default: return 12'($urandom_range(8, 255));
      endcase
   endfunction

   task automatic random_setting(input int phase);
      logic [11:0] dband;
      logic [11:0] maxc;
      logic [11:0] thr;
      logic [11:0] cycles;
      if (phase == 6) begin
         program_all(1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      end else if (phase == 7) begin
         program_all(1'b1, '0, '0, '0, '0, '0, '0, '0);
      end else begin
         dband  = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 200));
         maxc   = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(64, 2560));
         thr    = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(32, 600));
         cycles = {4'($urandom), 8'($urandom_range(0, 30))};
         program_all(phase != 5, pick_coef(), pick_coef(), pick_coef(), dband, maxc, thr,
                     cycles);
      end
   endtask

   initial begin
      int              sent;
      int              burst;
      int              roll;
      angle_style_type style;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(pack_word(-32768, 32767, -32768, 32767));
      send_word(pack_word(32767, -32768, 32767, -32768));

      program_all(1'b1, 12'd77, 12'd218, 12'd230, 12'd38, 12'd1024, 12'd192, 12'd15);
      send_word(pack_word(0, 0, 0, 0));
      send_word(pack_word(0, 0, 0, 0));
      send_word(pack_word(20, -20, 100, -100));
      send_word(pack_word(23040, -23040, 23040, -23040));
      send_word(pack_word(-23040, 23040, -23040, 23040));

      // Unity filter, so the deadband edge and the decay rounding are seen directly.
      program_all(1'b1, 12'd256, 12'd256, 12'd128, 12'd38, 12'd2560, 12'd192, 12'd1);
      send_word(pack_word(38, -38, 0, 0));
      send_word(pack_word(39, -39, 0, 0));
      send_word(pack_word(38, -38, 0, 0));

      program_all(1'b1, 12'd4095, 12'd300, 12'd256, 12'd0, 12'd4095, 12'd4095, 12'd0);
      send_word(pack_word(32767, -32768, -32768, 32767));
      send_word(pack_word(0, 0, 0, 0));
      write_one(REG_DECAY_FACTOR, 12'd0);
      send_word(pack_word(0, 0, 5, 5));

      write_one(REG_ENABLED, 12'd0);
      send_word(pack_word(100, 100, -7, 7));
      write_one(REG_ENABLED, 12'd0);
      send_word(pack_word(-100, 3000, 7, -7));
      write_one(REG_ENABLED, 12'd1);
      send_word(pack_word(1000, 1000, 0, 0));
      write_one(REG_ENABLED, 12'd1);
      send_word(pack_word(1000, -1000, 0, 0));

      for (int phase = 0; phase < 8; phase++) begin
         set_idling(phase % 4);
         random_setting(phase);
         sent = 0;
         while (sent < 68) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
               style = CALM_ANGLES;
               burst = $urandom_range(5, 40);
            end else if (roll < 9) begin
               style = MODERATE_ANGLES;
               burst = $urandom_range(1, 10);
            end else begin
               style = ANY_ANGLES;
               burst = $urandom_range(1, 5);
            end
            repeat (burst) send_word(random_word(style));
            sent += burst;
         end
      end

      drain();
      repeat (24) @(posedge clock);
      if (mismatches == 0 && words_in_flight == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/tcsf_pkg.sv
hdl/tcsf_lane.sv
hdl/tcsf_merge.sv
hdl/tilt_compensation_with_stability_flag.sv
bench/tilt_compensation_checker.sv
bench/testbench.sv
